// ===== src/b64d_pkg.sv =====
// ----------------------------------------------------------------------------
// b64d_pkg
// Shared types, codes and character tables of the base64 stream decoder.
// ----------------------------------------------------------------------------
package b64d_pkg;

  localparam logic [7:0]  CH_PLUS  = 8'd43;
  localparam logic [7:0]  CH_SLASH = 8'd47;
  localparam logic [7:0]  CH_EQ    = 8'd61;
  localparam logic [7:0]  CH_CR    = 8'd13;
  localparam logic [7:0]  CH_LF    = 8'd10;
  localparam logic [31:0] CAP_RESET = 32'hFFFF_FFFF;

  localparam logic REG_MODE = 1'b0;
  localparam logic REG_CAP  = 1'b1;

  typedef enum logic [1:0] {
    KIND_DATA = 2'd0,
    KIND_END  = 2'd1,
    KIND_ERR  = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_INVALID   = 2'd1,
    ST_MALFORMED = 2'd2,
    ST_NOSPACE   = 2'd3
  } status_t;

  // register contents seen by the decode core
  typedef struct packed {
    logic [3:0]  mode;
    logic [31:0] cap;
    logic        cap_wr;
  } cfg_t;

  // all results of one request, drained one per cycle while out_ready is high
  typedef struct packed {
    logic [1:0]  cnt;
    kind_t       kind;
    status_t     status;
    logic [23:0] word;
  } res_t;

  // bit 6 flags an alphabet character
  function automatic logic [6:0] sextet_of(input logic [7:0] c);
    logic [6:0] r;
    r = 7'd0;
    if (c >= 8'd65 && c <= 8'd90)       r = {1'b1, 6'(c - 8'd65)};
    else if (c >= 8'd97 && c <= 8'd122) r = {1'b1, 6'(c - 8'd71)};
    else if (c >= 8'd48 && c <= 8'd57)  r = {1'b1, 6'(c + 8'd4)};
    else if (c == CH_PLUS)              r = {1'b1, 6'd62};
    else if (c == CH_SLASH)             r = {1'b1, 6'd63};
    return r;
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c == 8'd32) || (c == CH_LF) || (c == CH_CR) || (c == 8'd9) ||
           (c == 8'd12) || (c == 8'd11);
  endfunction

endpackage

// ===== src/b64d_cfg.sv =====
// ----------------------------------------------------------------------------
// b64d_cfg
// APB register file: decode mode and output capacity.
// ----------------------------------------------------------------------------
module b64d_cfg
  import b64d_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg
);

  logic [3:0]  mode_r;
  logic [31:0] cap_r;
  logic        wr;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= 4'd0;
      cap_r  <= CAP_RESET;
    end else if (wr) begin
      unique case (paddr[2])
        REG_MODE: mode_r <= pwdata[3:0];
        REG_CAP:  cap_r  <= pwdata;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_MODE: prdata = {28'd0, mode_r};
      REG_CAP:  prdata = cap_r;
    endcase
  end

  // space left reloads together with the capacity write
  assign cfg.mode   = mode_r;
  assign cfg.cap    = cfg.cap_wr ? pwdata : cap_r;
  assign cfg.cap_wr = wr && (paddr[2] == REG_CAP);

endmodule

// ===== src/b64d_core.sv =====
// ----------------------------------------------------------------------------
// b64d_core
// Decode state and the per-character next-state and result logic.
// ----------------------------------------------------------------------------
module b64d_core
  import b64d_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  cfg_t       cfg,
  input  logic       fire,
  input  logic       req_end,
  input  logic [7:0] ch,
  output res_t       res
);

  logic [1:0]  cnt_r, cnt_nxt;
  logic [17:0] held_r, held_nxt;
  logic        cr_r, cr_nxt;
  logic        pad_r, pad_nxt;
  logic [31:0] space_r, space_nxt;
  logic        err_r, err_nxt;
  status_t     code_r, code_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= 2'd0;
      held_r  <= 18'd0;
      cr_r    <= 1'b0;
      pad_r   <= 1'b0;
      space_r <= CAP_RESET;
      err_r   <= 1'b0;
      code_r  <= ST_OK;
    end else begin
      cnt_r   <= cnt_nxt;
      held_r  <= held_nxt;
      cr_r    <= cr_nxt;
      pad_r   <= pad_nxt;
      space_r <= space_nxt;
      err_r   <= err_nxt;
      code_r  <= code_nxt;
    end
  end

  always_comb begin
    logic [6:0]  sx;
    logic        proc;
    logic        emit;
    logic [1:0]  emit_n;
    logic [23:0] emit_word;
    logic        raise;
    status_t     raise_code;
    status_t     end_st;

    sx         = sextet_of(ch);
    proc       = 1'b0;
    emit       = 1'b0;
    emit_n     = 2'd0;
    emit_word  = 24'd0;
    raise      = 1'b0;
    raise_code = ST_INVALID;
    end_st     = ST_OK;

    cnt_nxt   = cnt_r;
    held_nxt  = held_r;
    cr_nxt    = cr_r;
    pad_nxt   = pad_r;
    space_nxt = space_r;
    err_nxt   = err_r;
    code_nxt  = code_r;

    res.cnt    = 2'd0;
    res.kind   = KIND_DATA;
    res.status = ST_OK;
    res.word   = 24'd0;

    if (fire && req_end) begin
      priority if (err_r)     end_st = code_r;
      else if (cr_r)          end_st = ST_INVALID;
      else if (pad_r)         end_st = cfg.mode[0] ? ST_MALFORMED : ST_INVALID;
      else if (cnt_r != 2'd0) end_st = ST_MALFORMED;
      else                    end_st = ST_OK;
      res.cnt    = 2'd1;
      res.kind   = KIND_END;
      res.status = end_st;
      cnt_nxt    = 2'd0;
      held_nxt   = 18'd0;
      cr_nxt     = 1'b0;
      pad_nxt    = 1'b0;
      space_nxt  = cfg.cap;
      err_nxt    = 1'b0;
      code_nxt   = ST_OK;
    end else if (fire && !err_r) begin
      if (cr_r) begin
        cr_nxt = 1'b0;
        raise  = (ch != CH_LF);
      end else if (pad_r) begin
        pad_nxt = 1'b0;
        priority if (ch == CH_EQ) begin
          emit      = 1'b1;
          emit_n    = 2'd1;
          emit_word = {held_r[11:0], 12'd0};
        end else if (cfg.mode[0]) begin
          proc = 1'b1;
        end else begin
          raise = 1'b1;
        end
      end else begin
        proc = 1'b1;
      end

      if (proc) begin
        priority if (sx[6]) begin
          if (cnt_r != 2'd3) begin
            held_nxt = {held_r[11:0], sx[5:0]};
            cnt_nxt  = cnt_r + 2'd1;
          end else begin
            emit      = 1'b1;
            emit_n    = 2'd3;
            emit_word = {held_r, sx[5:0]};
          end
        end else if (ch == CH_EQ && cnt_r == 2'd3) begin
          emit      = 1'b1;
          emit_n    = 2'd2;
          emit_word = {held_r, 6'd0};
        end else if (ch == CH_EQ && cnt_r == 2'd2) begin
          pad_nxt = 1'b1;
        end else if (cfg.mode[0]) begin
          // every other non-alphabet character is dropped
        end else if (cfg.mode[1]) begin
          raise = !is_space(ch);
        end else if (ch == CH_CR && cfg.mode[2]) begin
          cr_nxt = 1'b1;
        end else if (ch == CH_LF && cfg.mode[3]) begin
          // bare line break allowed
        end else begin
          raise = 1'b1;
        end
      end

      // capacity is checked for the whole group before any byte goes out
      if (emit) begin
        if (space_r < {30'd0, emit_n}) begin
          raise      = 1'b1;
          raise_code = ST_NOSPACE;
        end else begin
          res.cnt   = emit_n;
          res.word  = emit_word;
          space_nxt = space_r - {30'd0, emit_n};
          cnt_nxt   = 2'd0;
          held_nxt  = 18'd0;
        end
      end

      if (raise) begin
        err_nxt    = 1'b1;
        code_nxt   = raise_code;
        res.cnt    = 2'd1;
        res.kind   = KIND_ERR;
        res.status = raise_code;
        res.word   = 24'd0;
      end
    end

    if (cfg.cap_wr) space_nxt = cfg.cap;
  end

endmodule

// ===== src/b64d_outbuf.sv =====
// ----------------------------------------------------------------------------
// b64d_outbuf
// Result register for one request's results, sent one per cycle on out_ready.
// ----------------------------------------------------------------------------
module b64d_outbuf
  import b64d_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       load,
  input  res_t       res,
  output logic       space_ok,
  output logic       out_valid,
  input  logic       out_ready,
  output kind_t      out_kind,
  output logic [7:0] out_byte,
  output status_t    out_status,
  output logic       out_last
);

  logic       valid_r;
  res_t       res_r;
  logic [1:0] idx_r;
  logic       pop;

  assign out_valid = valid_r;
  assign out_last  = (idx_r == (res_r.cnt - 2'd1));
  assign pop       = valid_r && out_ready;
  assign space_ok  = !valid_r || (out_ready && out_last);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load && res.cnt != 2'd0) begin
      valid_r <= 1'b1;
    end else if (pop && out_last) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load && res.cnt != 2'd0) begin
      res_r <= res;
      idx_r <= 2'd0;
    end else if (pop) begin
      idx_r <= idx_r + 2'd1;
    end
  end

  assign out_kind   = res_r.kind;
  assign out_status = res_r.status;

  always_comb begin
    unique case (idx_r)
      2'd0:    out_byte = res_r.word[23:16];
      2'd1:    out_byte = res_r.word[15:8];
      default: out_byte = res_r.word[7:0];
    endcase
  end

endmodule

// ===== src/base64_stream_decoder.sv =====
// ----------------------------------------------------------------------------
// base64_stream_decoder
// Base64 character stream decoder with padding, line break modes and
// capacity check.
// ----------------------------------------------------------------------------
// One character or end request is taken per clock cycle while in_ready is
// high; its results appear in the result register in the next cycle. A
// request that yields no result leaves the input free. A completed group
// gives one, two or three data bytes, sent one per cycle while out_ready is
// high; the input is held until the final result of a request is taken.
// Error and end reports are single results with last_of_run on the end
// report and on the final result of each request.
module base64_stream_decoder
  import b64d_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_req_type,
  input  logic [7:0]  in_char,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_result_kind,
  output logic [7:0]  out_data_byte,
  output logic [1:0]  out_status_code,
  output logic        out_last_of_run,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  cfg_t    cfg;
  res_t    res;
  logic    fire;
  logic    space_ok;
  kind_t   kind;
  status_t status;

  assign in_ready = space_ok;
  assign fire     = in_valid && in_ready;

  b64d_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  b64d_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .fire    (fire),
    .req_end (in_req_type),
    .ch      (in_char),
    .res     (res)
  );

  b64d_outbuf u_outbuf (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (fire),
    .res        (res),
    .space_ok   (space_ok),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_kind   (kind),
    .out_byte   (out_data_byte),
    .out_status (status),
    .out_last   (out_last_of_run)
  );

  assign out_result_kind = kind;
  assign out_status_code = status;

endmodule

// ===== tb/tb_base64_stream_decoder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_base64_stream_decoder
// Self-checking bench for the base64 stream decoder. Directed strings cover
// the alphabet extremes, padding, concatenated blocks, line break and skip
// modes, latched errors and the capacity check. Random encoded strings with
// noise then run under several register settings, with random stalls on
// both channels and one long output hold-off. Every result is compared with
// an in-bench decode model.
// ----------------------------------------------------------------------------
module tb_base64_stream_decoder;
  import b64d_pkg::*;

  localparam logic       REQ_CHAR = 1'b0;
  localparam logic       REQ_END  = 1'b1;
  localparam logic [3:0] MODE_SKIP_BAD = 4'b0001;
  localparam logic [3:0] MODE_SKIP_WS  = 4'b0010;
  localparam logic [3:0] MODE_CRLF     = 4'b0100;
  localparam logic [3:0] MODE_LF       = 4'b1000;
  localparam logic [7:0] CH_SPACE = 8'd32;
  localparam logic [7:0] CH_TAB   = 8'd9;
  localparam logic [7:0] CH_VT    = 8'd11;
  localparam logic [7:0] CH_FF    = 8'd12;
  localparam int HOLD_CYCLES  = 150;
  localparam int DRAIN_CYCLES = 10;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int PHASE_ITEMS  = 5;

  typedef struct {
    kind_t      kind;
    logic [7:0] data;
    status_t    status;
    logic       last;
  } decoded_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  wire         in_ready;
  logic        in_req_type = REQ_CHAR;
  logic [7:0]  in_char = 8'd0;
  wire         out_valid;
  logic        out_ready = 1'b0;
  wire  [1:0]  out_result_kind;
  wire  [7:0]  out_data_byte;
  wire  [1:0]  out_status_code;
  wire         out_last_of_run;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [2:0]  cfg_paddr = 3'd0;
  logic [31:0] cfg_pwdata = 32'd0;
  wire  [31:0] cfg_prdata;
  wire         cfg_pready;

  // decode model state
  logic [3:0]  m_mode;
  logic [31:0] m_cap;
  logic [1:0]  grp_cnt;
  logic [17:0] grp_bits;
  logic        cr_wait;
  logic        pad_wait;
  logic [31:0] room;
  logic        err_seen;
  status_t     err_code;

  decoded_t pending_results[$];
  int  fail_cnt = 0;
  int  items_sent = 0;
  int  cycle_cnt = 0;
  bit  tx_idle_on = 1'b1;
  bit  rx_idle_on = 1'b1;
  bit  hold_go = 1'b0;
  logic [7:0] ws_set[6] = '{CH_SPACE, CH_TAB, CH_LF, CH_VT, CH_FF, CH_CR};

  base64_stream_decoder DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_req_type(in_req_type), .in_char(in_char),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_result_kind(out_result_kind), .out_data_byte(out_data_byte),
    .out_status_code(out_status_code), .out_last_of_run(out_last_of_run),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata),
    .cfg_prdata(cfg_prdata), .cfg_pready(cfg_pready)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("tb_base64_stream_decoder: FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------- model

  function automatic int sextet_val(input logic [7:0] c);
    if (c >= 8'd65 && c <= 8'd90) return int'(c) - 65;
    if (c >= 8'd97 && c <= 8'd122) return int'(c) - 71;
    if (c >= 8'd48 && c <= 8'd57) return int'(c) + 4;
    if (c == CH_PLUS) return 62;
    if (c == CH_SLASH) return 63;
    return -1;
  endfunction

  function automatic logic [7:0] b64_char(input int v);
    if (v < 26) return 8'(65 + v);
    if (v < 52) return 8'(71 + v);
    if (v < 62) return 8'(v - 4);
    if (v == 62) return CH_PLUS;
    return CH_SLASH;
  endfunction

  function automatic bit ws_char(input logic [7:0] c);
    return c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_VT ||
           c == CH_FF || c == CH_CR;
  endfunction

  function automatic void push_result(input kind_t k, input logic [7:0] d,
                                      input status_t s);
    decoded_t r;
    r.kind = k;
    r.data = d;
    r.status = s;
    r.last = 1'b0;
    pending_results.push_back(r);
  endfunction

  function automatic void clear_string();
    grp_cnt = 2'd0;
    grp_bits = 18'd0;
    cr_wait = 1'b0;
    pad_wait = 1'b0;
    room = m_cap;
    err_seen = 1'b0;
    err_code = ST_OK;
  endfunction

  function automatic void flag_error(input status_t s);
    err_seen = 1'b1;
    err_code = s;
    push_result(KIND_ERR, 8'd0, s);
  endfunction

  // capacity is checked for the whole group before any byte goes out
  function automatic void emit_group(input logic [23:0] word, input int n);
    if (room < 32'(n)) begin
      flag_error(ST_NOSPACE);
    end else begin
      for (int i = 0; i < n; i++) push_result(KIND_DATA, word[23 - 8*i -: 8], ST_OK);
      room = room - 32'(n);
      grp_cnt = 2'd0;
      grp_bits = 18'd0;
    end
  endfunction

  function automatic void take_char(input logic [7:0] c);
    int v;
    v = sextet_val(c);
    if (v >= 0) begin
      if (grp_cnt < 2'd3) begin
        grp_bits = {grp_bits[11:0], 6'(v)};
        grp_cnt = grp_cnt + 2'd1;
      end else begin
        emit_group({grp_bits, 6'(v)}, 3);
      end
    end else if (c == CH_EQ && grp_cnt == 2'd3) begin
      emit_group({grp_bits, 6'd0}, 2);
    end else if (c == CH_EQ && grp_cnt == 2'd2) begin
      pad_wait = 1'b1;
    end else if ((m_mode & MODE_SKIP_BAD) != 0) begin
      // dropped silently
    end else if ((m_mode & MODE_SKIP_WS) != 0) begin
      if (!ws_char(c)) flag_error(ST_INVALID);
    end else if (c == CH_CR && (m_mode & MODE_CRLF) != 0) begin
      cr_wait = 1'b1;
    end else if (!(c == CH_LF && (m_mode & MODE_LF) != 0)) begin
      flag_error(ST_INVALID);
    end
  endfunction

  function automatic void predict_decode(input logic rt, input logic [7:0] c);
    int      n0;
    status_t st;
    n0 = pending_results.size();
    if (rt == REQ_END) begin
      st = ST_OK;
      if (err_seen) st = err_code;
      else if (cr_wait) st = ST_INVALID;
      else if (pad_wait) st = ((m_mode & MODE_SKIP_BAD) != 0) ? ST_MALFORMED : ST_INVALID;
      else if (grp_cnt != 2'd0) st = ST_MALFORMED;
      push_result(KIND_END, 8'd0, st);
      clear_string();
    end else if (err_seen) begin
      // ignored until the end request
    end else if (cr_wait) begin
      cr_wait = 1'b0;
      if (c != CH_LF) flag_error(ST_INVALID);
    end else if (pad_wait) begin
      pad_wait = 1'b0;
      if (c == CH_EQ) emit_group({grp_bits[11:0], 12'd0}, 1);
      else if ((m_mode & MODE_SKIP_BAD) != 0) take_char(c);
      else flag_error(ST_INVALID);
    end else begin
      take_char(c);
    end
    if (pending_results.size() > n0)
      pending_results[pending_results.size() - 1].last = 1'b1;
  endfunction

  // ---------------------------------------------------------------- checker

  always @(posedge clk) begin : result_check
    decoded_t e;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        fail_cnt++;
        if (fail_cnt <= 40)
          $display("%0t: unexpected result kind %0d byte %02h status %0d last %0b",
                   $time, out_result_kind, out_data_byte, out_status_code,
                   out_last_of_run);
      end else begin
        e = pending_results.pop_front();
        if (out_result_kind !== e.kind || out_data_byte !== e.data ||
            out_status_code !== e.status || out_last_of_run !== e.last) begin
          fail_cnt++;
          if (fail_cnt <= 40)
            $display("%0t: mismatch exp kind %0d byte %02h status %0d last %0b, %s %0d %02h %0d %0b",
                     $time, e.kind, e.data, e.status, e.last, "got",
                     out_result_kind, out_data_byte, out_status_code, out_last_of_run);
        end
      end
    end
  end

  // output side: random stalls, plus one long hold-off on request
  initial begin
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (hold_go) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_go = 1'b0;
        out_ready <= 1'b1;
      end else if (rx_idle_on && $urandom_range(0, 4) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------- drivers

  task automatic send_item(input logic rt, input logic [7:0] c);
    if (tx_idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req_type <= rt;
    in_char <= c;
    do @(posedge clk); while (!in_ready);
    predict_decode(rt, c);
    items_sent++;
  endtask

  task automatic send_str(input string s);
    for (int i = 0; i < s.len(); i++) send_item(REQ_CHAR, s[i]);
  endtask

  task automatic send_end();
    send_item(REQ_END, 8'($urandom_range(0, 255)));
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [31:0] val);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    if (idx == REG_MODE) begin
      m_mode = val[3:0];
    end else begin
      m_cap = val;
      room = val;
    end
  endtask

  task automatic set_regs(input logic [3:0] mode, input logic [31:0] cap);
    wait_idle();
    write_reg(REG_MODE, {28'd0, mode});
    write_reg(REG_CAP, cap);
  endtask

  task automatic send_noise();
    case ($urandom_range(0, 15))
      0: begin
        send_item(REQ_CHAR, CH_CR);
        send_item(REQ_CHAR, CH_LF);
      end
      1: send_item(REQ_CHAR, CH_LF);
      2: send_item(REQ_CHAR, ws_set[$urandom_range(0, 5)]);
      3: send_item(REQ_CHAR, 8'($urandom_range(0, 255)));
      default: ;
    endcase
  endtask

  task automatic send_random_string();
    int tail;
    repeat ($urandom_range(1, 2)) begin
      repeat ($urandom_range(0, 3)) repeat (4) begin
        send_noise();
        send_item(REQ_CHAR, b64_char($urandom_range(0, 63)));
      end
      tail = $urandom_range(0, 3);
      if (tail == 1) begin
        repeat (2) send_item(REQ_CHAR, b64_char($urandom_range(0, 63)));
        send_item(REQ_CHAR, CH_EQ);
        if ($urandom_range(0, 5) == 0) send_noise();
        send_item(REQ_CHAR, CH_EQ);
      end else if (tail == 2) begin
        repeat (3) send_item(REQ_CHAR, b64_char($urandom_range(0, 63)));
        send_item(REQ_CHAR, CH_EQ);
      end
    end
    // sometimes a stray character before the end
    if ($urandom_range(0, 9) == 0) send_item(REQ_CHAR, 8'($urandom_range(0, 255)));
    send_end();
  endtask

  task automatic run_phase(input logic [3:0] mode, input logic [31:0] cap);
    int stop_at;
    set_regs(mode, cap);
    stop_at = items_sent + PHASE_ITEMS;
    while (items_sent < stop_at) send_random_string();
  endtask

  // ---------------------------------------------------------------- tests

  task automatic test_alphabet_and_padding();
    set_regs(4'd0, CAP_RESET);
    send_str("+/9z");
    send_end();
    send_str("TWE=TQ==");
    send_end();
    send_str("TQ=x");
    send_end();
    send_str("A=");
    send_item(REQ_CHAR, 8'hFF);
    send_end();
    send_str("TQ=");
    send_end();
  endtask

  task automatic test_line_breaks();
    set_regs(MODE_CRLF, CAP_RESET);
    send_str("\r\nAB\rC");
    send_end();
    send_str("AB\r");
    send_end();
    set_regs(MODE_LF, CAP_RESET);
    send_str("\nTWFu\r");
    send_end();
  endtask

  task automatic test_skip_modes();
    // whitespace skip wins over the crlf rule
    set_regs(MODE_SKIP_WS | MODE_CRLF, CAP_RESET);
    send_str(" TW\tF");
    send_item(REQ_CHAR, CH_VT);
    send_item(REQ_CHAR, CH_FF);
    send_str("u\r!");
    send_end();
    set_regs(MODE_SKIP_BAD, CAP_RESET);
    send_item(REQ_CHAR, 8'h00);
    send_str("TQ=!");
    send_end();
    send_str("TQ=");
    send_end();
  endtask

  task automatic test_capacity();
    set_regs(4'd0, 32'd2);
    send_str("TWFuAAAA");
    send_end();
    set_regs(4'd0, 32'd0);
    send_str("TQ==");
    send_end();
    // a capacity write reloads the remaining room in mid string
    set_regs(4'd0, 32'd1);
    send_str("TQ==");
    wait_idle();
    write_reg(REG_CAP, 32'd1);
    send_str("TQ==");
    send_end();
  endtask

  task automatic test_random_mix();
    run_phase(4'd0, CAP_RESET);
    run_phase(4'hF, CAP_RESET);
    run_phase(MODE_CRLF | MODE_LF, 32'd0);
    run_phase(MODE_SKIP_WS, 32'd7);
    run_phase(MODE_SKIP_BAD | MODE_LF, 32'd12);
    run_phase(4'($urandom_range(0, 15)), 32'($urandom_range(0, 40)));
    run_phase(MODE_CRLF, CAP_RESET);
  endtask

  task automatic test_backpressure();
    set_regs(4'd0, CAP_RESET);
    hold_go = 1'b1;
    repeat (32) send_item(REQ_CHAR, b64_char($urandom_range(0, 63)));
    send_end();
  endtask

  task automatic test_quiet_tail();
    wait_idle();
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    run_phase(MODE_CRLF | MODE_LF, CAP_RESET);
  endtask

  initial begin
    m_mode = 4'd0;
    m_cap = CAP_RESET;
    clear_string();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_alphabet_and_padding();
    test_line_breaks();
    test_skip_modes();
    test_capacity();
    test_random_mix();
    test_backpressure();
    test_quiet_tail();
    wait_idle();
    if (fail_cnt == 0) begin
      $display("tb_base64_stream_decoder: PASS");
    end else begin
      $display("tb_base64_stream_decoder: FAIL");
    end
    $finish;
  end

endmodule

// ===== base64_stream_decoder.f =====
src/b64d_pkg.sv
src/b64d_cfg.sv
src/b64d_core.sv
src/b64d_outbuf.sv
src/base64_stream_decoder.sv
tb/tb_base64_stream_decoder.sv
